// ===== sv/ir_pulse_distance_transmitter_top_macros.svh =====
// Assertion macros shared by the pulse-distance transmitter RTL.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_TOP_MACROS_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define IPDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipdt same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define IPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipdt next-cycle check failed");
`else
`define IPDT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ipdt_pkg.sv =====
// Types and constants of the pulse-distance transmitter.
`timescale 1ns / 1ps
`default_nettype none
package ipdt_pkg;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_CARRIER_HIGH = 3'd0;
  localparam logic [2:0] REG_CARRIER_LOW  = 3'd1;
  localparam logic [2:0] REG_CARR_PER_UNIT = 3'd2;
  localparam logic [2:0] REG_SPACE_UNIT   = 3'd3;
  localparam logic [2:0] REG_LEAD_MARK    = 3'd4;
  localparam logic [2:0] REG_LEAD_SPACE   = 3'd5;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd6;
  localparam logic [2:0] REG_ZERO_SPACE   = 3'd7;

  // Register reset values
  localparam logic [7:0]  RST_CARRIER_HIGH  = 8'd52;
  localparam logic [9:0]  RST_CARRIER_LOW   = 10'd157;
  localparam logic [7:0]  RST_CARR_PER_UNIT = 8'd22;
  localparam logic [15:0] RST_SPACE_UNIT    = 16'd4496;
  localparam logic [5:0]  RST_LEAD_MARK     = 6'd16;
  localparam logic [5:0]  RST_LEAD_SPACE    = 6'd8;
  localparam logic [3:0]  RST_ONE_SPACE     = 4'd3;
  localparam logic [3:0]  RST_ZERO_SPACE    = 4'd1;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_WAIT       = 3'd5,
    PH_TRAIL      = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]  carrier_high_ticks;
    logic [9:0]  carrier_low_ticks;
    logic [7:0]  carriers_per_unit;
    logic [15:0] space_unit_ticks;
    logic [5:0]  leader_mark_units;
    logic [5:0]  leader_space_units;
    logic [3:0]  one_space_units;
    logic [3:0]  zero_space_units;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic ir_out;
    logic ready_res;
    logic accepted;
  } res_t;

  typedef struct packed {
    phase_t phase;
    logic   byte_pending;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/ipdt_cfg.sv =====
// APB-style configuration register file of the pulse-distance transmitter.
`timescale 1ns / 1ps
`default_nettype none
module ipdt_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ipdt_pkg::cfg_t      cfg
);
  import ipdt_pkg::*;

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_high_ticks <= RST_CARRIER_HIGH;
      cfg_r.carrier_low_ticks  <= RST_CARRIER_LOW;
      cfg_r.carriers_per_unit  <= RST_CARR_PER_UNIT;
      cfg_r.space_unit_ticks   <= RST_SPACE_UNIT;
      cfg_r.leader_mark_units  <= RST_LEAD_MARK;
      cfg_r.leader_space_units <= RST_LEAD_SPACE;
      cfg_r.one_space_units    <= RST_ONE_SPACE;
      cfg_r.zero_space_units   <= RST_ZERO_SPACE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CARRIER_HIGH:  cfg_r.carrier_high_ticks <= pwdata[7:0];
        REG_CARRIER_LOW:   cfg_r.carrier_low_ticks  <= pwdata[9:0];
        REG_CARR_PER_UNIT: cfg_r.carriers_per_unit  <= pwdata[7:0];
        REG_SPACE_UNIT:    cfg_r.space_unit_ticks   <= pwdata[15:0];
        REG_LEAD_MARK:     cfg_r.leader_mark_units  <= pwdata[5:0];
        REG_LEAD_SPACE:    cfg_r.leader_space_units <= pwdata[5:0];
        REG_ONE_SPACE:     cfg_r.one_space_units    <= pwdata[3:0];
        REG_ZERO_SPACE:    cfg_r.zero_space_units   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CARRIER_HIGH:  prdata = {24'd0, cfg_r.carrier_high_ticks};
      REG_CARRIER_LOW:   prdata = {22'd0, cfg_r.carrier_low_ticks};
      REG_CARR_PER_UNIT: prdata = {24'd0, cfg_r.carriers_per_unit};
      REG_SPACE_UNIT:    prdata = {16'd0, cfg_r.space_unit_ticks};
      REG_LEAD_MARK:     prdata = {26'd0, cfg_r.leader_mark_units};
      REG_LEAD_SPACE:    prdata = {26'd0, cfg_r.leader_space_units};
      REG_ONE_SPACE:     prdata = {28'd0, cfg_r.one_space_units};
      REG_ZERO_SPACE:    prdata = {28'd0, cfg_r.zero_space_units};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ipdt_engine.sv =====
// Frame sequencer: phase, counters and shift byte, advanced once per item.
`timescale 1ns / 1ps
`default_nettype none
module ipdt_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ipdt_pkg::item_t     item,
  input  ipdt_pkg::cfg_t      cfg,
  output ipdt_pkg::res_t      res,
  output ipdt_pkg::status_t   status
);
  import ipdt_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  carr_r, carr_nxt;
  logic [5:0]  unit_r, unit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic        end_pend_r, end_pend_nxt;
  logic        byte_pend_r, byte_pend_nxt;

  logic        is_mark;
  logic        can_load;
  logic        took;
  logic [15:0] period;
  logic [15:0] tick_inc;
  logic [7:0]  carr_inc;
  logic [5:0]  unit_inc;
  logic [5:0]  units;
  logic        tick_wrap;
  logic        carr_wrap;
  logic        unit_step;
  logic        seg_done;

  assign is_mark  = (phase_r == PH_LEAD_MARK) || (phase_r == PH_BIT_MARK) ||
                    (phase_r == PH_TRAIL);
  assign can_load = (phase_r == PH_IDLE) || (phase_r == PH_WAIT);
  assign took     = (item.command == CMD_LOAD) && can_load;

  // Segment counters: ticks per period or space unit, periods, units
  assign period   = {5'd0, {3'd0, cfg.carrier_high_ticks} + {1'b0, cfg.carrier_low_ticks}};
  assign tick_inc = tick_r + 16'd1;
  assign carr_inc = carr_r + 8'd1;
  assign unit_inc = unit_r + 6'd1;

  always_comb begin
    case (phase_r)
      PH_LEAD_MARK:  units = cfg.leader_mark_units;
      PH_LEAD_SPACE: units = cfg.leader_space_units;
      PH_BIT_SPACE:  units = shift_r[0] ? {2'd0, cfg.one_space_units}
                                        : {2'd0, cfg.zero_space_units};
      default:       units = 6'd1;
    endcase
  end

  assign tick_wrap = is_mark ? !(tick_inc < period) : !(tick_inc < cfg.space_unit_ticks);
  assign carr_wrap = tick_wrap && !(carr_inc < cfg.carriers_per_unit);
  assign unit_step = is_mark ? carr_wrap : tick_wrap;
  assign seg_done  = unit_step && !(unit_inc < units);

  // Next state for one item
  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    carr_nxt      = carr_r;
    unit_nxt      = unit_r;
    shift_nxt     = shift_r;
    bit_idx_nxt   = bit_idx_r;
    end_pend_nxt  = end_pend_r;
    byte_pend_nxt = byte_pend_r;
    if (item.command == CMD_LOAD) begin
      // Take a byte only when idle or between bytes; else drop the load
      if (can_load) begin
        shift_nxt     = item.data_byte;
        bit_idx_nxt   = 3'd0;
        byte_pend_nxt = 1'b1;
        end_pend_nxt  = item.frame_end;
        tick_nxt      = 16'd0;
        carr_nxt      = 8'd0;
        unit_nxt      = 6'd0;
        phase_nxt     = item.frame_start ? PH_LEAD_MARK : PH_BIT_MARK;
      end
    end else begin
      case (phase_r)
        PH_IDLE, PH_WAIT: ;
        PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_TRAIL: begin
          // Advance the segment counters
          tick_nxt = tick_wrap ? 16'd0 : tick_inc;
          if (is_mark && tick_wrap) begin
            carr_nxt = carr_wrap ? 8'd0 : carr_inc;
          end
          if (unit_step) begin
            unit_nxt = seg_done ? 6'd0 : unit_inc;
          end
          if (seg_done) begin
            tick_nxt = 16'd0;
            carr_nxt = 8'd0;
            case (phase_r)
              PH_LEAD_MARK:  phase_nxt = PH_LEAD_SPACE;
              PH_LEAD_SPACE: phase_nxt = PH_BIT_MARK;
              PH_BIT_MARK:   phase_nxt = PH_BIT_SPACE;
              PH_BIT_SPACE: begin
                shift_nxt   = {1'b0, shift_r[7:1]};
                bit_idx_nxt = bit_idx_r + 3'd1;
                if (bit_idx_r == 3'd7) begin
                  byte_pend_nxt = 1'b0;
                  phase_nxt     = end_pend_r ? PH_TRAIL : PH_WAIT;
                end else begin
                  phase_nxt = PH_BIT_MARK;
                end
              end
              default: begin
                phase_nxt    = PH_IDLE;
                end_pend_nxt = 1'b0;
              end
            endcase
          end
        end
        default: begin
          // Recover from an unused phase code
          phase_nxt = PH_IDLE;
          tick_nxt  = 16'd0;
          carr_nxt  = 8'd0;
          unit_nxt  = 6'd0;
        end
      endcase
    end
  end

  // Result: level before the item, readiness after it
  assign res.ir_out    = is_mark && (tick_r < {8'd0, cfg.carrier_high_ticks});
  assign res.ready_res = (phase_nxt == PH_IDLE) || (phase_nxt == PH_WAIT);
  assign res.accepted  = took;

  assign status.phase        = phase_r;
  assign status.byte_pending = byte_pend_r;

  // Hold state until an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= 16'd0;
      carr_r      <= 8'd0;
      unit_r      <= 6'd0;
      shift_r     <= 8'd0;
      bit_idx_r   <= 3'd0;
      end_pend_r  <= 1'b0;
      byte_pend_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      carr_r      <= carr_nxt;
      unit_r      <= unit_nxt;
      shift_r     <= shift_nxt;
      bit_idx_r   <= bit_idx_nxt;
      end_pend_r  <= end_pend_nxt;
      byte_pend_r <= byte_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ir_pulse_distance_transmitter_top.sv =====
// Top level of the pulse-distance infrared transmitter.
// An accepted item is held in the input register; its result is then captured in the result register and offered.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being drained.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// sequencer goes idle with all counters cleared, and both stages empty.
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_distance_transmitter_top_macros.svh"
module ir_pulse_distance_transmitter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ir_out,
  output logic        out_ready_res,
  output logic        out_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ipdt_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    s1_adv;
  logic    out_valid_r;
  res_t    out_res_r;
  cfg_t    cfg;
  res_t    eng_res;
  status_t eng_status;

  ipdt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipdt_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_valid_r & s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .res    (eng_res),
    .status (eng_status)
  );

  // Move the staged item on when the result register has room
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.command     <= in_command;
      s1_item_r.data_byte   <= in_data_byte;
      s1_item_r.frame_start <= in_frame_start;
      s1_item_r.frame_end   <= in_frame_end;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ir_out    = out_res_r.ir_out;
  assign out_ready_res = out_res_r.ready_res;
  assign out_accepted  = out_res_r.accepted;

  // A taken load always starts a busy segment with the pin low
  `IPDT_ASSERT_NOW(a_load_busy, clk, rst_n, out_valid && out_accepted, !out_ready_res && !out_ir_out)
  // A staged item that cannot move holds its place
  `IPDT_ASSERT_NEXT(a_stage_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_item_r))
  // A pending byte exists exactly while leader or bit segments run
  `IPDT_ASSERT_NOW(a_pending_phase, clk, rst_n, 1'b1, eng_status.byte_pending == ((eng_status.phase == PH_LEAD_MARK) || (eng_status.phase == PH_LEAD_SPACE) || (eng_status.phase == PH_BIT_MARK) || (eng_status.phase == PH_BIT_SPACE)))
  // An empty input register always takes an item
  `IPDT_ASSERT_NOW(a_empty_ready, clk, rst_n, !s1_valid_r, in_ready)

endmodule
`default_nettype wire
